// ----- rtl/core/pcam_pkg.sv -----
// package for the partition counter: widths, word types, controller states and commands
package pcam_pkg;

    localparam int unsigned TOTAL_W     = 10;
    localparam int unsigned LIMIT_W     = 5;
    localparam int unsigned COUNT_W     = 64;
    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned MAX_PARTS   = 31;

    localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned J_W     = $clog2(MAX_PARTS + 2);
    localparam int unsigned N_MAX   = TABLE_DEPTH - 1;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [LIMIT_W-1:0] part_limit;
    } query_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               saturated;
        logic               bad_request;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPDATE,
        ST_FINAL_RD,
        ST_FINAL_WAIT,
        ST_EMIT,
        ST_BAD
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic upd_issue;
        logic final_issue;
        logic emit_ans;
        logic emit_bad;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic clear_last;
        logic upd_have;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/pcam_ram.sv -----
// generic ram: one write port, two read ports with registered read data
module pcam_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/core/pcam_ctrl.sv -----
// controller state machine for the partition counter
module pcam_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    input  pcam_pkg::status_t status,
    output logic              query_ready,
    output pcam_pkg::cmd_t    cmd
);
    import pcam_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    state_next = status.in_bad ? ST_BAD : ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!status.upd_have)
                begin
                    state_next = ST_FINAL_RD;
                end
            end
            ST_FINAL_RD:   state_next = ST_FINAL_WAIT;
            ST_FINAL_WAIT: state_next = ST_EMIT;
            ST_EMIT, ST_BAD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        query_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                query_ready = 1'b1;
                cmd.load    = query_valid;
            end
            ST_CLEAR:    cmd.clear_step  = 1'b1;
            ST_UPDATE:   cmd.upd_issue   = status.upd_have;
            ST_FINAL_RD: cmd.final_issue = 1'b1;
            ST_EMIT:     cmd.emit_ans    = status.out_free;
            ST_BAD:      cmd.emit_bad    = status.out_free;
            default:     cmd             = '0;
        endcase
    end

endmodule

// ----- rtl/core/pcam_dp.sv -----
// datapath: loop counters, table ram, saturating add with forwarding, result register
module pcam_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  pcam_pkg::cmd_t    cmd,
    input  pcam_pkg::query_t  query,
    input  logic              result_ready,
    output pcam_pkg::status_t status,
    output logic              result_valid,
    output pcam_pkg::result_t result
);
    import pcam_pkg::*;

    logic [ADDR_W-1:0]  n_reg;
    logic [J_W-1:0]     m_reg;
    logic [J_W-1:0]     j_reg;
    logic [ADDR_W-1:0]  k_reg;
    logic               ovf_reg;

    // second stage of the update pipe
    logic               p1_wr_reg;
    logic               p1_final_reg;
    logic [ADDR_W-1:0]  p1_addr_reg;
    logic               fwd_a_reg;
    logic               fwd_b_reg;
    logic [COUNT_W-1:0] fwd_data_reg;
    logic [COUNT_W-1:0] ans_reg;

    logic               result_valid_reg;
    result_t            result_reg;

    logic [ADDR_W-1:0]  rd_a;
    logic [ADDR_W-1:0]  rd_b;
    logic [COUNT_W-1:0] ram_a;
    logic [COUNT_W-1:0] ram_b;
    logic [COUNT_W-1:0] a_val;
    logic [COUNT_W-1:0] b_val;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] sat_val;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic               issue;

    assign issue = cmd.upd_issue | cmd.final_issue;
    assign rd_a  = cmd.final_issue ? n_reg : k_reg;
    assign rd_b  = k_reg - ADDR_W'(j_reg);

    assign a_val   = fwd_a_reg ? fwd_data_reg : ram_a;
    assign b_val   = fwd_b_reg ? fwd_data_reg : ram_b;
    assign sum     = {1'b0, a_val} + {1'b0, b_val};
    assign sat_val = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = k_reg;
            ram_wdata = (k_reg == '0) ? COUNT_W'(1) : '0;
        end
        else
        begin
            ram_we    = p1_wr_reg;
            ram_waddr = p1_addr_reg;
            ram_wdata = sat_val;
        end
    end

    pcam_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr_a(rd_a),
        .raddr_b(rd_b),
        .rdata_a(ram_a),
        .rdata_b(ram_b)
    );

    assign status.in_bad     = (query.part_limit == '0);
    assign status.clear_last = (k_reg == n_reg);
    assign status.upd_have   = (j_reg <= m_reg) && (32'(j_reg) <= 32'(n_reg));
    assign status.out_free   = !result_valid_reg || result_ready;

    // loop counters and per-query state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // totals and limits beyond the table are clamped
            n_reg   <= (32'(query.total) > N_MAX) ? ADDR_W'(N_MAX) : ADDR_W'(query.total);
            m_reg   <= (32'(query.part_limit) > MAX_PARTS) ? J_W'(MAX_PARTS)
                                                           : J_W'(query.part_limit);
            k_reg   <= '0;
            j_reg   <= J_W'(1);
            ovf_reg <= 1'b0;
        end
        else if (cmd.clear_step)
        begin
            if (k_reg == n_reg)
            begin
                k_reg <= ADDR_W'(1);
                j_reg <= J_W'(1);
            end
            else
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end
        end
        else if (cmd.upd_issue)
        begin
            if (k_reg == n_reg)
            begin
                j_reg <= j_reg + J_W'(1);
                k_reg <= ADDR_W'(j_reg) + ADDR_W'(1);
            end
            else
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end
        end

        if (p1_wr_reg && sum[COUNT_W])
        begin
            ovf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_wr_reg    <= 1'b0;
            p1_final_reg <= 1'b0;
        end
        else
        begin
            p1_wr_reg    <= cmd.upd_issue;
            p1_final_reg <= cmd.final_issue;
        end
    end

    // an entry written this cycle is read back stale, so forward it
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_addr_reg  <= rd_a;
            fwd_a_reg    <= p1_wr_reg && (p1_addr_reg == rd_a);
            fwd_b_reg    <= p1_wr_reg && (p1_addr_reg == rd_b);
            fwd_data_reg <= sat_val;
        end
        if (p1_final_reg)
        begin
            ans_reg <= a_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ans || cmd.emit_bad)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ans)
        begin
            result_reg.count       <= ans_reg;
            result_reg.saturated   <= ovf_reg;
            result_reg.bad_request <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            result_reg.count       <= '0;
            result_reg.saturated   <= 1'b0;
            result_reg.bad_request <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/partition_count_at_most_m_parts_top.sv -----
// top level of the partition counter: controller, datapath and checks
// one query at a time; a query with total n and part limit m clears table entries 0..n,
//   then makes one table update per cycle through the two-read table ram for each part size
//   j=1..min(m,n) over entries j..n, then reads entry n and emits the result
// a zero part limit gives a bad-request result; the result register frees the input side
// reset is asynchronous, active low; the table is left undefined and each query rewrites 0..n
module partition_count_at_most_m_parts_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_ready,
    input  pcam_pkg::query_t  query,
    output logic              result_valid,
    input  logic              result_ready,
    output pcam_pkg::result_t result
);
    import pcam_pkg::*;

    cmd_t    cmd;
    status_t status;

    pcam_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .query_valid(query_valid),
        .status     (status),
        .query_ready(query_ready),
        .cmd        (cmd)
    );

    pcam_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .query       (query),
        .result_ready(result_ready),
        .status      (status),
        .result_valid(result_valid),
        .result      (result)
    );

    // a result is never loaded over one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ans || cmd.emit_bad) |-> (!result_valid || result_ready))
        else $error("result loaded while output busy");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clear_step, cmd.upd_issue, cmd.final_issue,
                  cmd.emit_ans, cmd.emit_bad}))
        else $error("more than one datapath command");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (query_valid && query_ready) |=> !query_ready)
        else $error("new word taken while a query is running");

    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.bad_request) |-> (result.count == '0 && !result.saturated))
        else $error("bad request word carries a count");

endmodule
